FILE: src/dpqt_pkg.sv
// ----------------------------------------------------------------------------
// dpqt_pkg
// Shared widths, register indexes, reset values and interface types for the
// dual pulse qualifier totalizer.
// ----------------------------------------------------------------------------
package dpqt_pkg;

  localparam int TIME_W     = 17;
  localparam int THR_W      = 3;
  localparam int STEP_W     = 16;
  localparam int CNT_W      = 32;
  localparam int SAMPLE_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;

  localparam logic [TIME_W-1:0] LOCKOUT_RESET   = 17'd10;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RESET      = 16'd100;

  typedef struct packed {
    logic              qual_a;
    logic              qual_b;
    logic [TIME_W-1:0] now;
  } front_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] lockout;
    logic [STEP_W-1:0] step;
  } back_cfg_t;

endpackage

FILE: src/dpqt_front.sv
// ----------------------------------------------------------------------------
// dpqt_front
// Burst classifier: trailing low run of each enabled channel against the
// run threshold.
// ----------------------------------------------------------------------------
module dpqt_front import dpqt_pkg::*; #(
  parameter int SAMPLES_PER_BURST = 6
) (
  input  logic                enable_a,
  input  logic                enable_b,
  input  logic [SAMPLE_W-1:0] samples_a,
  input  logic [SAMPLE_W-1:0] samples_b,
  input  logic [TIME_W-1:0]   now_seconds,
  input  logic [THR_W-1:0]    run_threshold,
  output front_item_t         item
);

  localparam int RUN_W = $clog2(SAMPLES_PER_BURST + 1);
  localparam int CMP_W = (RUN_W > THR_W) ? RUN_W : THR_W;
  localparam int IDX_W = $clog2(SAMPLE_W);

  function automatic logic qualifies(input logic en, input logic [SAMPLE_W-1:0] s,
                                     input logic [THR_W-1:0] thr);
    logic             found;
    logic [IDX_W-1:0] hi;
    logic [RUN_W-1:0] run;
    found = 1'b0;
    hi    = '0;
    // highest high sample inside the burst window
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (i < SAMPLES_PER_BURST && s[i]) begin
        found = 1'b1;
        hi    = IDX_W'(i);
      end
    end
    if (found) begin
      run = RUN_W'(SAMPLES_PER_BURST - 1 - int'(hi));
    end else begin
      run = RUN_W'(SAMPLES_PER_BURST);
    end
    return en && (CMP_W'(run) > CMP_W'(thr));
  endfunction

  always_comb begin
    item.qual_a = qualifies(enable_a, samples_a, run_threshold);
    item.qual_b = qualifies(enable_b, samples_b, run_threshold);
    item.now    = now_seconds;
  end

endmodule

FILE: src/dpqt_fifo.sv
// ----------------------------------------------------------------------------
// dpqt_fifo
// Two-entry queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module dpqt_fifo import dpqt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output front_item_t pop_item
);

  front_item_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= 2'd2) && !(pop && count == 2'd0) && !(push && count == 2'd2))
    else $error("queue over or underflow");

endmodule

FILE: src/dpqt_back.sv
// ----------------------------------------------------------------------------
// dpqt_back
// Accumulator: per-channel lockout and pulse counters, then the committed
// total, with a registered result.
// ----------------------------------------------------------------------------
module dpqt_back import dpqt_pkg::*; #(
  parameter int SECONDS_PER_DAY = 86400
) (
  input  logic             clk,
  input  logic             rst,
  input  back_cfg_t        cfg,
  input  logic             item_valid,
  input  front_item_t      item,
  output logic             item_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             accepted_a,
  output logic             accepted_b,
  output logic [CNT_W-1:0] count_a,
  output logic [CNT_W-1:0] count_b,
  output logic [CNT_W-1:0] total_value,
  output logic             save_request
);

  localparam int EL_W = TIME_W + 1;

  logic [TIME_W-1:0] last_a;
  logic [TIME_W-1:0] last_b;
  logic [CNT_W-1:0]  pulses_a;
  logic [CNT_W-1:0]  pulses_b;
  logic              s1_valid;
  logic              s1_acc_a;
  logic              s1_acc_b;
  logic [CNT_W-1:0]  total;

  logic              s1_adv;
  logic              acc_a_next;
  logic              acc_b_next;
  logic [CNT_W-1:0]  least;
  logic [CNT_W-1:0]  target;
  logic              save_next;

  function automatic logic past_lockout(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] then,
                                        input logic [TIME_W-1:0] lockout);
    logic [EL_W-1:0] wrapped;
    logic [EL_W-1:0] elapsed;
    wrapped = {1'b0, now};
    if (now < then) begin
      wrapped = wrapped + EL_W'(SECONDS_PER_DAY);
    end
    elapsed = wrapped - {1'b0, then};
    return elapsed > {1'b0, lockout};
  endfunction

  assign s1_adv     = s1_valid && (!out_valid || out_ready);
  assign item_pop   = item_valid && (!s1_valid || s1_adv);
  assign acc_a_next = item.qual_a && past_lockout(item.now, last_a, cfg.lockout);
  assign acc_b_next = item.qual_b && past_lockout(item.now, last_b, cfg.lockout);

  assign least     = (pulses_a <= pulses_b) ? pulses_a : pulses_b;
  assign target    = total + CNT_W'(cfg.step);
  assign save_next = (least >= target);

  // stage one: lockout and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      last_a   <= '0;
      last_b   <= '0;
      pulses_a <= '0;
      pulses_b <= '0;
      s1_valid <= 1'b0;
      s1_acc_a <= 1'b0;
      s1_acc_b <= 1'b0;
    end else begin
      if (item_pop) begin
        s1_valid <= 1'b1;
        s1_acc_a <= acc_a_next;
        s1_acc_b <= acc_b_next;
        if (acc_a_next) begin
          last_a   <= item.now;
          pulses_a <= pulses_a + 1'b1;
        end
        if (acc_b_next) begin
          last_b   <= item.now;
          pulses_b <= pulses_b + 1'b1;
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // stage two: committed total and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid <= 1'b1;
        if (save_next) begin
          total <= least;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      accepted_a   <= s1_acc_a;
      accepted_b   <= s1_acc_b;
      count_a      <= pulses_a;
      count_b      <= pulses_b;
      total_value  <= save_next ? least : total;
      save_request <= save_next;
    end
  end

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    item_pop && acc_a_next |=> pulses_a == $past(pulses_a) + 1'b1)
    else $error("channel a counter did not advance on accepted pulse");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(item_pop && acc_b_next) |=> pulses_b == $past(pulses_b))
    else $error("channel b counter moved without accepted pulse");

  a_save_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && save_request |->
      total_value == ((count_a <= count_b) ? count_a : count_b))
    else $error("saved total differs from smaller count");

endmodule

FILE: src/dual_pulse_qualifier_totalizer.sv
// ----------------------------------------------------------------------------
// dual_pulse_qualifier_totalizer
// Two-channel meter pulse qualifier with lockout, pulse counters and a
// stepped committed total.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, enable_*, samples_*,   sink
//            now_seconds
//   out      out_valid/out_ready, accepted_*, count_*, source
//            total_value, save_request
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  sink, always ready
//
// one burst per cycle sustained while out_ready stays high; a result passes
// through the queue, counter stage and total stage registers
// reset clears counters, last times, total and registers to their defaults
// a stalled output backs up the total stage, counter stage and two-entry
// queue before in_ready drops
// ----------------------------------------------------------------------------
module dual_pulse_qualifier_totalizer import dpqt_pkg::*; #(
  parameter int SAMPLES_PER_BURST = 6,
  parameter int SECONDS_PER_DAY   = 86400
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  enable_a,
  input  logic                  enable_b,
  input  logic [SAMPLE_W-1:0]   samples_a,
  input  logic [SAMPLE_W-1:0]   samples_b,
  input  logic [TIME_W-1:0]     now_seconds,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  accepted_a,
  output logic                  accepted_b,
  output logic [CNT_W-1:0]      count_a,
  output logic [CNT_W-1:0]      count_b,
  output logic [CNT_W-1:0]      total_value,
  output logic                  save_request,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TIME_W-1:0] lockout_seconds;
  logic [THR_W-1:0]  run_threshold;
  logic [STEP_W-1:0] total_step;

  front_item_t front_item;
  front_item_t queue_item;
  back_cfg_t   back_cfg;
  logic        queue_full;
  logic        queue_valid;
  logic        queue_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_seconds <= LOCKOUT_RESET;
      run_threshold   <= THRESHOLD_RESET;
      total_step      <= STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOCKOUT:   lockout_seconds <= cfg_data[TIME_W-1:0];
        CFG_THRESHOLD: run_threshold   <= cfg_data[THR_W-1:0];
        CFG_STEP:      total_step      <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.lockout = lockout_seconds;
  assign back_cfg.step    = total_step;

  dpqt_front #(
    .SAMPLES_PER_BURST(SAMPLES_PER_BURST)
  ) u_front (
    .enable_a      (enable_a),
    .enable_b      (enable_b),
    .samples_a     (samples_a),
    .samples_b     (samples_b),
    .now_seconds   (now_seconds),
    .run_threshold (run_threshold),
    .item          (front_item)
  );

  dpqt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_valid),
    .pop_item  (queue_item)
  );

  dpqt_back #(
    .SECONDS_PER_DAY(SECONDS_PER_DAY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (back_cfg),
    .item_valid   (queue_valid),
    .item         (queue_item),
    .item_pop     (queue_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted_a   (accepted_a),
    .accepted_b   (accepted_b),
    .count_a      (count_a),
    .count_b      (count_b),
    .total_value  (total_value),
    .save_request (save_request)
  );

endmodule

FILE: tb/sv/dpqt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpqt_result_checker
// Watches the burst, configuration and result channels of the dual pulse
// qualifier totalizer, predicts every result from its own copy of the
// registers, last pulse times, pulse counters and committed total, and
// compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module dpqt_result_checker import dpqt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  enable_a,
  input  logic                  enable_b,
  input  logic [SAMPLE_W-1:0]   samples_a,
  input  logic [SAMPLE_W-1:0]   samples_b,
  input  logic [TIME_W-1:0]     now_seconds,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  accepted_a,
  input  logic                  accepted_b,
  input  logic [CNT_W-1:0]      count_a,
  input  logic [CNT_W-1:0]      count_b,
  input  logic [CNT_W-1:0]      total_value,
  input  logic                  save_request,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int          BURST_LEN    = 6;
  localparam logic [31:0] DAY_SECONDS  = 32'd86400;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic             acc_a;
    logic             acc_b;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
    logic [CNT_W-1:0] total;
    logic             save;
  } tally_t;

  logic [TIME_W-1:0] lockout_reg;
  logic [THR_W-1:0]  threshold_reg;
  logic [STEP_W-1:0] step_reg;
  logic [TIME_W-1:0] last_a;
  logic [TIME_W-1:0] last_b;
  logic [CNT_W-1:0]  pulses_a;
  logic [CNT_W-1:0]  pulses_b;
  logic [CNT_W-1:0]  total_reg;
  tally_t            tally_queue[$];
  int                misses;

  initial begin
    fail_count = 0;
    pending    = 0;
    misses     = 0;
  end

  function automatic int low_run(logic en, logic [SAMPLE_W-1:0] s);
    int run;
    run = 0;
    if (en) begin
      for (int i = 0; i < BURST_LEN; i++) begin
        run = s[i] ? 0 : run + 1;
      end
    end
    return run;
  endfunction

  function automatic logic [31:0] since_last(logic [TIME_W-1:0] now,
                                             logic [TIME_W-1:0] last);
    logic [31:0] t;
    t = 32'(now);
    if (t < 32'(last)) begin
      t = t + DAY_SECONDS;
    end
    return t - 32'(last);
  endfunction

  function automatic string show(tally_t r);
    return $sformatf("acc_a=%0b acc_b=%0b count_a=%0d count_b=%0d total=%0d save=%0b",
                     r.acc_a, r.acc_b, r.cnt_a, r.cnt_b, r.total, r.save);
  endfunction

  task automatic tally_burst();
    int          run_a;
    int          run_b;
    tally_t      r;
    logic [31:0] least;
    r     = '0;
    run_a = low_run(enable_a, samples_a);
    run_b = low_run(enable_b, samples_b);
    if (run_a > int'(threshold_reg) && since_last(now_seconds, last_a) > 32'(lockout_reg)) begin
      last_a   = now_seconds;
      pulses_a = pulses_a + 32'd1;
      r.acc_a  = 1'b1;
    end
    if (run_b > int'(threshold_reg) && since_last(now_seconds, last_b) > 32'(lockout_reg)) begin
      last_b   = now_seconds;
      pulses_b = pulses_b + 32'd1;
      r.acc_b  = 1'b1;
    end
    least = (pulses_a <= pulses_b) ? pulses_a : pulses_b;
    if (least >= total_reg + 32'(step_reg)) begin
      total_reg = least;
      r.save    = 1'b1;
    end
    r.cnt_a = pulses_a;
    r.cnt_b = pulses_b;
    r.total = total_reg;
    tally_queue.push_back(r);
  endtask

  task automatic check_result();
    tally_t exp_r;
    tally_t act_r;
    act_r = {accepted_a, accepted_b, count_a, count_b, total_value, save_request};
    if (tally_queue.size() == 0) begin
      if (misses < REPORT_LIMIT) begin
        $display("%0t: result with nothing outstanding: %s", $realtime, show(act_r));
      end
      misses++;
    end else begin
      exp_r = tally_queue.pop_front();
      if (act_r !== exp_r) begin
        if (misses < REPORT_LIMIT) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", show(exp_r));
          $display("  actual   %s", show(act_r));
        end
        misses++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lockout_reg   = LOCKOUT_RESET;
      threshold_reg = THRESHOLD_RESET;
      step_reg      = STEP_RESET;
      last_a        = '0;
      last_b        = '0;
      pulses_a      = '0;
      pulses_b      = '0;
      total_reg     = '0;
      tally_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOCKOUT: begin
            lockout_reg = cfg_data[TIME_W-1:0];
          end
          CFG_THRESHOLD: begin
            threshold_reg = cfg_data[THR_W-1:0];
          end
          CFG_STEP: begin
            step_reg = cfg_data[STEP_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        tally_burst();
      end
    end
    fail_count <= misses;
    pending    <= tally_queue.size();
  end

endmodule

FILE: tb/sv/dual_pulse_qualifier_totalizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pulse_qualifier_totalizer_test
// Drives sampling bursts and register writes into the dual pulse qualifier
// totalizer: a directed set of lockout, run, wrap and out of range time
// cases, then random bursts under several register settings, with bursty
// input, a stalling result side and one long result hold-off.
// ----------------------------------------------------------------------------
module dual_pulse_qualifier_totalizer_test;
  import dpqt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DAY_SECONDS    = 86400;
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AFTER     = 250;
  localparam int HOLD_CYCLES    = 60;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  enable_a = 1'b0;
  logic                  enable_b = 1'b0;
  logic [SAMPLE_W-1:0]   samples_a = '0;
  logic [SAMPLE_W-1:0]   samples_b = '0;
  logic [TIME_W-1:0]     now_seconds = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  accepted_a;
  logic                  accepted_b;
  logic [CNT_W-1:0]      count_a;
  logic [CNT_W-1:0]      count_b;
  logic [CNT_W-1:0]      total_value;
  logic                  save_request;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int sent_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int clock_sec = 0;
  bit quiet_sender = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int seg_left = 0;
  int stall_mode = 0;

  dual_pulse_qualifier_totalizer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .enable_a     (enable_a),
    .enable_b     (enable_b),
    .samples_a    (samples_a),
    .samples_b    (samples_b),
    .now_seconds  (now_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted_a   (accepted_a),
    .accepted_b   (accepted_b),
    .count_a      (count_a),
    .count_b      (count_b),
    .total_value  (total_value),
    .save_request (save_request),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dpqt_result_checker CHECK (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .enable_a     (enable_a),
    .enable_b     (enable_b),
    .samples_a    (samples_a),
    .samples_b    (samples_b),
    .now_seconds  (now_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted_a   (accepted_a),
    .accepted_b   (accepted_b),
    .count_a      (count_a),
    .count_b      (count_b),
    .total_value  (total_value),
    .save_request (save_request),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sent_count <= sent_count + 1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side: segments of stall patterns plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AFTER) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        seg_left   <= $urandom_range(1, 40);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  task automatic send_burst(logic ea, logic eb, logic [SAMPLE_W-1:0] sa,
                            logic [SAMPLE_W-1:0] sb, logic [TIME_W-1:0] ts);
    int gap;
    in_valid    <= 1'b1;
    enable_a    <= ea;
    enable_b    <= eb;
    samples_a   <= sa;
    samples_b   <= sb;
    now_seconds <= ts;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || out_valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly a trailing low run of random length after random leading samples
  function automatic logic [SAMPLE_W-1:0] shaped_samples();
    int k;
    k = $urandom_range(0, SAMPLE_W);
    if ($urandom_range(0, 3) == 0) begin
      return SAMPLE_W'($urandom);
    end
    return SAMPLE_W'($urandom) & ((SAMPLE_W'(1) << k) - SAMPLE_W'(1));
  endfunction

  task automatic random_bursts(int n, int max_advance);
    logic [TIME_W-1:0] ts;
    for (int i = 0; i < n; i++) begin
      clock_sec = (clock_sec + $urandom_range(0, max_advance)) % DAY_SECONDS;
      ts = ($urandom_range(0, 15) == 0) ? TIME_W'($urandom) : TIME_W'(clock_sec);
      send_burst($urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                 shaped_samples(), shaped_samples(), ts);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: lockout 10, run above 3, step 100
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd0);
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd11);
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd21);
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd22);
    send_burst(1'b0, 1'b1, 6'b000000, 6'b111111, 17'd40);
    send_burst(1'b1, 1'b1, 6'b000111, 6'b000011, 17'd60);
    send_burst(1'b1, 1'b1, 6'b100000, 6'b011111, 17'd80);
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd5);
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd86399);
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd131071);
    send_burst(1'b1, 1'b1, 6'b000000, 6'b000000, 17'd3);
    send_burst(1'b1, 1'b1, 6'b111111, 6'b111111, 17'd100000);
    send_burst(1'b1, 1'b0, 6'b000000, 6'b000000, 17'd200);
    send_burst(1'b1, 1'b1, 6'b010101, 6'b101010, 17'd300);
    send_burst(1'b1, 1'b1, 6'b001111, 6'b000001, 17'd400);
    clock_sec = 400;

    write_reg(CFG_LOCKOUT, 17'd0);
    write_reg(CFG_THRESHOLD, 17'd0);
    write_reg(CFG_STEP, 17'd1);
    random_bursts(120, 3);

    write_reg(CFG_LOCKOUT, 17'h1FFFF);
    write_reg(CFG_THRESHOLD, 17'd6);
    write_reg(CFG_STEP, 17'h10000);
    random_bursts(40, 2000);

    write_reg(CFG_LOCKOUT, 17'd86399);
    write_reg(CFG_THRESHOLD, 17'h1FFFF);
    write_reg(CFG_STEP, 17'd65535);
    write_reg(CFG_UNUSED, 17'h1FFFF);
    random_bursts(30, 50000);

    write_reg(CFG_LOCKOUT, 17'd5);
    write_reg(CFG_THRESHOLD, 17'd2);
    write_reg(CFG_STEP, 17'd3);
    quiet_sender = 1'b1;
    random_bursts(150, 8);
    quiet_sender = 1'b0;

    write_reg(CFG_LOCKOUT, 17'($urandom_range(0, 30)));
    write_reg(CFG_THRESHOLD, 17'($urandom_range(0, 5)));
    write_reg(CFG_STEP, 17'($urandom_range(1, 20)));
    random_bursts(150, 20);

    write_reg(CFG_LOCKOUT, 17'(LOCKOUT_RESET));
    write_reg(CFG_THRESHOLD, 17'(THRESHOLD_RESET));
    write_reg(CFG_STEP, 17'(STEP_RESET));
    random_bursts(100, 15);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
